/* design/pedestal_subtracted_window_integrator_defines.svh */
// Assertion macros used by the checker file of the integrator.
// Stand-alone header; it needs nothing else.
`ifndef PEDESTAL_SUBTRACTED_WINDOW_INTEGRATOR_DEFINES_SVH
`define PEDESTAL_SUBTRACTED_WINDOW_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psw_chk: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define PSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psw_chk: next-cycle property violated");

`endif

/* design/psw_pkg.sv */
// Package of the pedestal-subtracted window integrator: widths, types, range table.
// Has no dependencies; the interfaces, psw_accum, psw_div, the top level and the testbench use it.
`timescale 1ns / 1ps

package psw_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned RedW      = 8;
  localparam int unsigned CntW      = 13;
  localparam int unsigned SumW      = 21;
  localparam int unsigned PedAbsW   = SumW - 1;
  localparam int unsigned RangeIdxW = 4;
  localparam int unsigned MvW       = 16;
  localparam int unsigned FsW       = 15;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = CntW;
  localparam int unsigned ChargeW   = 41;
  localparam int unsigned PedW      = 25;
  localparam int unsigned MulAW     = 34;
  localparam int unsigned MulBW     = 16;
  localparam int unsigned ProdW     = MulAW + MulBW + 1;
  localparam int unsigned NumW      = 66;
  localparam int unsigned DenW      = 28;
  localparam int unsigned MagW      = NumW + 1;
  localparam int unsigned ChargeShift = 17;
  localparam int unsigned PedShift    = 16;

  localparam logic [CntW-1:0] MaxSamples    = 13'd4096;
  localparam logic [FsW-1:0]  FullScaleCode = 15'd32512;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAPTURE_LENGTH = 3'd0,
    CFG_INT_START      = 3'd1,
    CFG_INT_STOP       = 3'd2,
    CFG_PED_START      = 3'd3,
    CFG_PED_STOP       = 3'd4,
    CFG_RANGE_CHAN_A   = 3'd5,
    CFG_RANGE_CHAN_B   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CntW-1:0]      capture_length;
    logic [CntW-1:0]      int_start;
    logic [CntW-1:0]      int_stop;
    logic [CntW-1:0]      ped_start;
    logic [CntW-1:0]      ped_stop;
    logic [RangeIdxW-1:0] range_chan_a;
    logic [RangeIdxW-1:0] range_chan_b;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    capture_length: 13'd100,
    int_start:      13'd0,
    int_stop:       13'd4096,
    ped_start:      13'd0,
    ped_stop:       13'd0,
    range_chan_a:   4'd6,
    range_chan_b:   4'd7
  };

  typedef struct packed {
    logic                   last;
    logic signed [SumW-1:0] int_total;
    logic signed [SumW-1:0] ped_total;
    logic [CntW-1:0]        n_int;
    logic [CntW-1:0]        n_ped;
  } acc_info_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] mag;
  } div_rsp_t;

  function automatic logic [MvW-1:0] range_mv(input logic [RangeIdxW-1:0] idx);
    logic [MvW-1:0] mv;
    unique case (idx)
      4'd0:    mv = 16'd10;
      4'd1:    mv = 16'd20;
      4'd2:    mv = 16'd50;
      4'd3:    mv = 16'd100;
      4'd4:    mv = 16'd200;
      4'd5:    mv = 16'd500;
      4'd6:    mv = 16'd1000;
      4'd7:    mv = 16'd2000;
      4'd8:    mv = 16'd5000;
      4'd9:    mv = 16'd10000;
      4'd10:   mv = 16'd20000;
      default: mv = 16'd50000;
    endcase
    return mv;
  endfunction

endpackage

/* design/psw_if.sv */
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on psw_pkg for the payload widths.
`timescale 1ns / 1ps

interface psw_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [psw_pkg::SampleW-1:0]     raw_sample;
  logic                                   chan_sel;

  modport source (output valid, output raw_sample, output chan_sel, input ready);
  modport sink (input valid, input raw_sample, input chan_sel, output ready);
endinterface

interface psw_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [psw_pkg::ChargeW-1:0]     charge_fixed;
  logic signed [psw_pkg::PedW-1:0]        pedestal_fixed;

  modport source (output valid, output charge_fixed, output pedestal_fixed, input ready);
  modport sink (input valid, input charge_fixed, input pedestal_fixed, output ready);
endinterface

/* design/psw_accum.sv */
// Per-sample front end: reduces samples to 8 bits and sums the two clipped windows.
// Depends on psw_pkg.
`timescale 1ns / 1ps

module psw_accum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic signed [psw_pkg::SampleW-1:0]  raw_sample_i,
  input  psw_pkg::cfg_t                       cfg_i,
  output psw_pkg::acc_info_t                  info_o
);

  logic [psw_pkg::CntW-1:0]          count_q, count_d;
  logic signed [psw_pkg::SumW-1:0]   int_sum_q, int_sum_d;
  logic signed [psw_pkg::SumW-1:0]   ped_sum_q, ped_sum_d;
  logic [psw_pkg::CntW-1:0]          len;
  logic [psw_pkg::CntW-1:0]          int_stop;
  logic [psw_pkg::CntW-1:0]          ped_stop;
  logic                              ped_on;
  logic                              in_int;
  logic                              in_ped;
  logic signed [psw_pkg::SampleW-1:0] biased;
  logic signed [psw_pkg::RedW-1:0]   red;
  logic signed [psw_pkg::SumW-1:0]   red_ext;

  always_comb begin
    if (cfg_i.capture_length == '0) begin
      len = psw_pkg::CntW'(1);
    end else if (cfg_i.capture_length > psw_pkg::MaxSamples) begin
      len = psw_pkg::MaxSamples;
    end else begin
      len = cfg_i.capture_length;
    end
    int_stop = (cfg_i.int_stop < len) ? cfg_i.int_stop : len;
    ped_stop = (cfg_i.ped_stop < len) ? cfg_i.ped_stop : len;
    ped_on   = (cfg_i.ped_start != cfg_i.ped_stop);
    in_int   = (count_q >= cfg_i.int_start) && (count_q < int_stop);
    in_ped   = ped_on && (count_q >= cfg_i.ped_start) && (count_q < ped_stop);

    // Adding 255 to negative samples makes the arithmetic shift truncate toward zero.
    biased  = raw_sample_i + $signed({{psw_pkg::RedW{1'b0}},
              {(psw_pkg::SampleW - psw_pkg::RedW){raw_sample_i[psw_pkg::SampleW-1]}}});
    red     = biased[psw_pkg::SampleW-1 -: psw_pkg::RedW];
    red_ext = psw_pkg::SumW'(red);

    info_o.last      = (count_q >= len - psw_pkg::CntW'(1));
    info_o.int_total = int_sum_q + (in_int ? red_ext : '0);
    info_o.ped_total = ped_sum_q + (in_ped ? red_ext : '0);
    info_o.n_int     = (int_stop > cfg_i.int_start) ? int_stop - cfg_i.int_start : '0;
    info_o.n_ped     = (ped_on && (ped_stop > cfg_i.ped_start)) ?
                       ped_stop - cfg_i.ped_start : '0;

    count_d   = count_q;
    int_sum_d = int_sum_q;
    ped_sum_d = ped_sum_q;
    if (accept_i) begin
      if (info_o.last) begin
        count_d   = '0;
        int_sum_d = '0;
        ped_sum_d = '0;
      end else begin
        count_d   = count_q + psw_pkg::CntW'(1);
        int_sum_d = info_o.int_total;
        ped_sum_d = info_o.ped_total;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      int_sum_q <= '0;
      ped_sum_q <= '0;
    end else begin
      count_q   <= count_d;
      int_sum_q <= int_sum_d;
      ped_sum_q <= ped_sum_d;
    end
  end

endmodule

/* design/psw_div.sv */
// Shared restoring divider, one quotient bit per cycle, rounding half up at the end.
// Depends on psw_pkg.
`timescale 1ns / 1ps

module psw_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psw_pkg::div_req_t   req_i,
  output psw_pkg::div_rsp_t   rsp_o
);

  localparam int unsigned StepW = $clog2(psw_pkg::NumW + 1);

  logic [psw_pkg::NumW-1:0] work_q, work_d;
  logic [psw_pkg::DenW-1:0] rem_q, rem_d;
  logic [psw_pkg::DenW-1:0] den_q, den_d;
  logic [psw_pkg::MagW-1:0] mag_q, mag_d;
  logic [StepW-1:0]         step_q, step_d;
  logic                     busy_q, busy_d;
  logic                     fin_q, fin_d;
  logic                     done_q, done_d;
  logic [psw_pkg::DenW:0]   shifted;
  logic [psw_pkg::DenW:0]   trial;

  always_comb begin
    shifted = {rem_q, work_q[psw_pkg::NumW-1]};
    trial   = shifted - {1'b0, den_q};

    work_d = work_q;
    rem_d  = rem_q;
    den_d  = den_q;
    mag_d  = mag_q;
    step_d = step_q;
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;

    if (req_i.start) begin
      work_d = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      step_d = StepW'(psw_pkg::NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[psw_pkg::DenW]) begin
        rem_d  = trial[psw_pkg::DenW-1:0];
        work_d = {work_q[psw_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_d  = shifted[psw_pkg::DenW-1:0];
        work_d = {work_q[psw_pkg::NumW-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      mag_d  = psw_pkg::MagW'(work_q) +
               psw_pkg::MagW'({rem_q, 1'b0} >= {1'b0, den_q});
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    mag_q  <= mag_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.mag  = mag_q;

endmodule

/* design/pedestal_subtracted_window_integrator.sv */
// Top level of the pedestal-subtracted window integrator: configuration, sequencer,
// shared multiplier. Depends on psw_pkg, psw_if, psw_accum and psw_div.
`timescale 1ns / 1ps

// Samples of a capture are taken one per cycle and summed over the pedestal and the
// integration window. The last sample of a capture starts the charge and pedestal
// computation on one shared multiplier and one 66-step divider, and the block drops
// ready until the result request has been taken, which also waits out any stall on
// the result side. Configuration writes take effect at the next clock edge.
module pedestal_subtracted_window_integrator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [psw_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [psw_pkg::CfgDataW-1:0]      cfg_data_i,
  psw_in_if.sink                            sample_i,
  psw_out_if.source                         result_o
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_MUL_I = 11'b00000000010,
    ST_MUL_P = 11'b00000000100,
    ST_DIFF  = 11'b00000001000,
    ST_ABS   = 11'b00000010000,
    ST_MUL_N = 11'b00000100000,
    ST_DIV_C = 11'b00001000000,
    ST_PED_D = 11'b00010000000,
    ST_PED_N = 11'b00100000000,
    ST_DIV_P = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_e;

  state_e                               state_q, state_d;
  psw_pkg::cfg_t                        cfg_q, cfg_d;
  psw_pkg::acc_info_t                   info;
  psw_pkg::div_req_t                    div_req;
  psw_pkg::div_rsp_t                    div_rsp;
  logic                                 accept;
  logic                                 start_q, start_d;
  logic signed [psw_pkg::SumW-1:0]      int_sum_q, int_sum_d;
  logic signed [psw_pkg::SumW-1:0]      ped_sum_q, ped_sum_d;
  logic [psw_pkg::CntW-1:0]             n_int_q, n_int_d;
  logic [psw_pkg::CntW-1:0]             n_ped_q, n_ped_d;
  logic [psw_pkg::CntW-1:0]             nd_q, nd_d;
  logic [psw_pkg::MvW-1:0]              mv_q, mv_d;
  logic [psw_pkg::PedAbsW-1:0]          ped_abs_q, ped_abs_d;
  logic                                 ped_neg_q, ped_neg_d;
  logic                                 neg_q, neg_d;
  logic signed [psw_pkg::MulAW-1:0]     acc_q, acc_d;
  logic signed [psw_pkg::ProdW-1:0]     prod_q, prod_d;
  logic [psw_pkg::DenW-1:0]             den_q, den_d;
  logic signed [psw_pkg::ChargeW-1:0]   charge_q, charge_d;
  logic signed [psw_pkg::PedW-1:0]      ped_q, ped_d;
  logic signed [psw_pkg::MulAW-1:0]     mul_a;
  logic [psw_pkg::MulBW-1:0]            mul_b;
  logic signed [psw_pkg::ProdW-1:0]     mul_p;
  logic                                 charge_big;
  logic                                 ped_big;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;

  assign result_o.valid          = (state_q == ST_OUT);
  assign result_o.charge_fixed   = charge_q;
  assign result_o.pedestal_fixed = ped_q;

  psw_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .raw_sample_i (sample_i.raw_sample),
    .cfg_i        (cfg_q),
    .info_o       (info)
  );

  assign div_req.start = start_q;
  assign div_req.num   = (state_q == ST_DIV_P) ?
    {prod_q[psw_pkg::NumW-psw_pkg::PedShift-1:0], {psw_pkg::PedShift{1'b0}}} :
    {prod_q[psw_pkg::NumW-psw_pkg::ChargeShift-1:0], {psw_pkg::ChargeShift{1'b0}}};
  assign div_req.den   = den_q;

  psw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign mul_p      = mul_a * $signed({1'b0, mul_b});
  assign charge_big = |div_rsp.mag[psw_pkg::MagW-1:psw_pkg::ChargeW-1];
  assign ped_big    = |div_rsp.mag[psw_pkg::MagW-1:psw_pkg::PedW-1];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (psw_pkg::cfg_idx_e'(cfg_idx_i))
        psw_pkg::CFG_CAPTURE_LENGTH: cfg_d.capture_length = cfg_data_i;
        psw_pkg::CFG_INT_START:      cfg_d.int_start      = cfg_data_i;
        psw_pkg::CFG_INT_STOP:       cfg_d.int_stop       = cfg_data_i;
        psw_pkg::CFG_PED_START:      cfg_d.ped_start      = cfg_data_i;
        psw_pkg::CFG_PED_STOP:       cfg_d.ped_stop       = cfg_data_i;
        psw_pkg::CFG_RANGE_CHAN_A:
          cfg_d.range_chan_a = cfg_data_i[psw_pkg::RangeIdxW-1:0];
        psw_pkg::CFG_RANGE_CHAN_B:
          cfg_d.range_chan_b = cfg_data_i[psw_pkg::RangeIdxW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    start_d   = 1'b0;
    int_sum_d = int_sum_q;
    ped_sum_d = ped_sum_q;
    n_int_d   = n_int_q;
    n_ped_d   = n_ped_q;
    nd_d      = nd_q;
    mv_d      = mv_q;
    ped_abs_d = ped_abs_q;
    ped_neg_d = ped_neg_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    den_d     = den_q;
    charge_d  = charge_q;
    ped_d     = ped_q;
    mul_a     = '0;
    mul_b     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && info.last) begin
          int_sum_d = info.int_total;
          ped_sum_d = info.ped_total;
          n_int_d   = info.n_int;
          n_ped_d   = info.n_ped;
          nd_d      = (info.n_ped == '0) ? psw_pkg::CntW'(1) : info.n_ped;
          mv_d      = psw_pkg::range_mv(sample_i.chan_sel ? cfg_q.range_chan_b :
                                                            cfg_q.range_chan_a);
          state_d   = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        mul_a     = psw_pkg::MulAW'(int_sum_q);
        mul_b     = psw_pkg::MulBW'(nd_q);
        prod_d    = mul_p;
        ped_neg_d = ped_sum_q[psw_pkg::SumW-1];
        ped_abs_d = ped_sum_q[psw_pkg::SumW-1] ? psw_pkg::PedAbsW'(-ped_sum_q) :
                                                 psw_pkg::PedAbsW'(ped_sum_q);
        state_d   = ST_MUL_P;
      end
      ST_MUL_P: begin
        mul_a   = psw_pkg::MulAW'(ped_sum_q);
        mul_b   = psw_pkg::MulBW'(n_int_q);
        acc_d   = prod_q[psw_pkg::MulAW-1:0];
        prod_d  = mul_p;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        mul_a   = psw_pkg::MulAW'($signed({1'b0, psw_pkg::FullScaleCode}));
        mul_b   = psw_pkg::MulBW'(nd_q);
        acc_d   = acc_q - prod_q[psw_pkg::MulAW-1:0];
        prod_d  = mul_p;
        state_d = ST_ABS;
      end
      ST_ABS: begin
        den_d   = prod_q[psw_pkg::DenW-1:0];
        neg_d   = !acc_q[psw_pkg::MulAW-1] && (acc_q != '0);
        acc_d   = acc_q[psw_pkg::MulAW-1] ? -acc_q : acc_q;
        state_d = ST_MUL_N;
      end
      ST_MUL_N: begin
        mul_a   = acc_q;
        mul_b   = mv_q;
        prod_d  = mul_p;
        start_d = 1'b1;
        state_d = ST_DIV_C;
      end
      ST_DIV_C: begin
        if (div_rsp.done) begin
          if (neg_q) begin
            charge_d = charge_big ? {1'b1, {(psw_pkg::ChargeW-1){1'b0}}} :
                                    -div_rsp.mag[psw_pkg::ChargeW-1:0];
          end else begin
            charge_d = charge_big ? {1'b0, {(psw_pkg::ChargeW-1){1'b1}}} :
                                    div_rsp.mag[psw_pkg::ChargeW-1:0];
          end
          if (n_ped_q != '0) begin
            state_d = ST_PED_D;
          end else begin
            ped_d   = '0;
            state_d = ST_OUT;
          end
        end
      end
      ST_PED_D: begin
        mul_a   = psw_pkg::MulAW'($signed({1'b0, psw_pkg::FullScaleCode}));
        mul_b   = psw_pkg::MulBW'(n_ped_q);
        prod_d  = mul_p;
        state_d = ST_PED_N;
      end
      ST_PED_N: begin
        mul_a   = psw_pkg::MulAW'($signed({1'b0, ped_abs_q}));
        mul_b   = mv_q;
        den_d   = prod_q[psw_pkg::DenW-1:0];
        prod_d  = mul_p;
        start_d = 1'b1;
        state_d = ST_DIV_P;
      end
      ST_DIV_P: begin
        if (div_rsp.done) begin
          if (ped_neg_q) begin
            ped_d = ped_big ? {1'b1, {(psw_pkg::PedW-1){1'b0}}} :
                              -div_rsp.mag[psw_pkg::PedW-1:0];
          end else begin
            ped_d = ped_big ? {1'b0, {(psw_pkg::PedW-1){1'b1}}} :
                              div_rsp.mag[psw_pkg::PedW-1:0];
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (result_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
      cfg_q   <= psw_pkg::CfgReset;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      cfg_q   <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    int_sum_q <= int_sum_d;
    ped_sum_q <= ped_sum_d;
    n_int_q   <= n_int_d;
    n_ped_q   <= n_ped_d;
    nd_q      <= nd_d;
    mv_q      <= mv_d;
    ped_abs_q <= ped_abs_d;
    ped_neg_q <= ped_neg_d;
    neg_q     <= neg_d;
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    den_q     <= den_d;
    charge_q  <= charge_d;
    ped_q     <= ped_d;
  end

endmodule

/* design/psw_chk.sv */
// Port-level checker for the integrator, bound to the top level.
// Depends on psw_if and the assertion macros header.
`timescale 1ns / 1ps
`include "pedestal_subtracted_window_integrator_defines.svh"

module psw_chk (
  input logic        clk_i,
  input logic        rst_ni,
  psw_in_if.sink     in_mon,
  psw_out_if.source  out_mon
);

  `PSW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_mon.valid && !out_mon.ready, out_mon.valid)
  `PSW_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_mon.valid && !out_mon.ready, $stable(out_mon.charge_fixed) && $stable(out_mon.pedestal_fixed))
  `PSW_ASSERT_IMP(a_busy_while_result, clk_i, rst_ni, out_mon.valid, !in_mon.ready)
  `PSW_ASSERT_IMP(a_result_after_work, clk_i, rst_ni, $rose(out_mon.valid), !$past(in_mon.ready))
  `PSW_ASSERT_NXT(a_ready_after_result, clk_i, rst_ni, out_mon.valid && out_mon.ready, in_mon.ready)

endmodule

bind pedestal_subtracted_window_integrator psw_chk u_psw_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .in_mon  (sample_i),
  .out_mon (result_o)
);

/* tb/tb_pedestal_subtracted_window_integrator.sv */
// Self-checking testbench for the pedestal-subtracted window integrator.
// Streams captures through the valid/ready channels, predicts each charge and pedestal result,
// and compares them in order. Depends on psw_pkg, psw_if and the integrator RTL.
`timescale 1ns / 1ps

module tb_pedestal_subtracted_window_integrator;

  typedef struct {
    logic signed [psw_pkg::SampleW-1:0] raw;
    logic                               chan;
  } sample_t;

  typedef struct {
    logic signed [psw_pkg::ChargeW-1:0] charge;
    logic signed [psw_pkg::PedW-1:0]    ped;
  } charge_t;

  localparam logic [psw_pkg::CfgIdxW-1:0] CfgIdxSpare = 3'd7;
  localparam longint unsigned FullScale = 64'(psw_pkg::FullScaleCode);
  localparam int CycleLimit = 2000000;
  localparam int TotalItems = 1650;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [psw_pkg::CfgIdxW-1:0] cfg_idx;
  logic [psw_pkg::CfgDataW-1:0] cfg_data;

  psw_in_if  smp_if ();
  psw_out_if res_if ();

  pedestal_subtracted_window_integrator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (smp_if),
    .result_o   (res_if)
  );

  sample_t sample_q[$];
  charge_t charge_q[$];
  psw_pkg::cfg_t cfg_model;
  int unsigned smp_index = 0;
  longint int_acc = 0;
  longint ped_acc = 0;
  int samples_pushed = 0;
  int samples_taken = 0;
  int captures_checked = 0;
  int fail_count = 0;
  int gap_left;
  int stall_left;
  int cycle_count = 0;
  bit idle_on = 1'b1;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned round_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    return q;
  endfunction

  function automatic longint clamp_to_width(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint unsigned range_in_mv(input int unsigned idx);
    case (idx)
      0:       return 10;
      1:       return 20;
      2:       return 50;
      3:       return 100;
      4:       return 200;
      5:       return 500;
      6:       return 1000;
      7:       return 2000;
      8:       return 5000;
      9:       return 10000;
      10:      return 20000;
      default: return 50000;
    endcase
  endfunction

  // Accumulates one sample and, on the last sample of a capture, queues the expected result.
  function automatic void integrate_sample(input logic signed [psw_pkg::SampleW-1:0] raw,
                                           input logic chan);
    int red;
    int unsigned len, istop, pstop, n_int, n_ped, idx;
    bit ped_on;
    longint d, chg, ped;
    longint unsigned nd, k, ad, q, r, a, q1, rem1, b, mag, ap, mv;
    charge_t res;
    red = int'(raw) / 256;
    len = 32'(cfg_model.capture_length);
    if (len == 0) len = 1;
    if (len > psw_pkg::MaxSamples) len = 32'(psw_pkg::MaxSamples);
    istop = (cfg_model.int_stop < len) ? 32'(cfg_model.int_stop) : len;
    pstop = (cfg_model.ped_stop < len) ? 32'(cfg_model.ped_stop) : len;
    ped_on = (cfg_model.ped_start != cfg_model.ped_stop);
    if (smp_index >= cfg_model.int_start && smp_index < istop) int_acc += longint'(red);
    if (ped_on && smp_index >= cfg_model.ped_start && smp_index < pstop) begin
      ped_acc += longint'(red);
    end
    if (smp_index + 1 < len) begin
      smp_index++;
      return;
    end

    n_int = (istop > cfg_model.int_start) ? istop - 32'(cfg_model.int_start) : 0;
    n_ped = (ped_on && pstop > cfg_model.ped_start) ? pstop - 32'(cfg_model.ped_start) : 0;
    idx = chan ? 32'(cfg_model.range_chan_b) : 32'(cfg_model.range_chan_a);
    if (idx > 11) idx = 11;
    mv = range_in_mv(idx);

    nd = (n_ped != 0) ? 64'(n_ped) : 1;
    k = 64'd131072 * mv;
    d = int_acc * longint'(nd) - ped_acc * longint'(n_int);
    ad = (d < 0) ? -d : d;
    q = ad / nd;
    r = ad % nd;
    a = k * q;
    q1 = a / FullScale;
    rem1 = a % FullScale;
    b = rem1 * nd + k * r;
    mag = q1 + round_div(b, FullScale * nd);
    if (mag > (64'd1 << 41)) mag = 64'd1 << 41;
    chg = (d > 0) ? -longint'(mag) : longint'(mag);
    res.charge = psw_pkg::ChargeW'(clamp_to_width(chg, psw_pkg::ChargeW));

    if (n_ped != 0) begin
      k = 64'd65536 * mv;
      ap = (ped_acc < 0) ? -ped_acc : ped_acc;
      mag = round_div(k * ap, FullScale * 64'(n_ped));
      if (mag > (64'd1 << 25)) mag = 64'd1 << 25;
      ped = (ped_acc < 0) ? -longint'(mag) : longint'(mag);
      res.ped = psw_pkg::PedW'(clamp_to_width(ped, psw_pkg::PedW));
    end else begin
      res.ped = '0;
    end
    charge_q.push_back(res);
    smp_index = 0;
    int_acc = 0;
    ped_acc = 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t item;
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
      smp_if.raw_sample <= '0;
      smp_if.chan_sel <= 1'b0;
      gap_left <= 0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        integrate_sample(smp_if.raw_sample, smp_if.chan_sel);
        samples_taken++;
      end
      if (!smp_if.valid || smp_if.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          smp_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 14);
          smp_if.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          item = sample_q.pop_front();
          smp_if.valid <= 1'b1;
          smp_if.raw_sample <= item.raw;
          smp_if.chan_sel <= item.chan;
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    charge_t exp_res;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (charge_q.size() == 0) begin
          $error("unexpected result request: charge_fixed=%0d pedestal_fixed=%0d",
                 res_if.charge_fixed, res_if.pedestal_fixed);
          fail_count++;
        end else begin
          exp_res = charge_q.pop_front();
          captures_checked++;
          if (res_if.charge_fixed !== exp_res.charge) begin
            $error("charge_fixed: expected %0d, actual %0d", exp_res.charge,
                   res_if.charge_fixed);
            fail_count++;
          end
          if (res_if.pedestal_fixed !== exp_res.ped) begin
            $error("pedestal_fixed: expected %0d, actual %0d", exp_res.ped,
                   res_if.pedestal_fixed);
            fail_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 14);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("pedestal_subtracted_window_integrator test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [psw_pkg::CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= psw_pkg::CfgDataW'(val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      psw_pkg::CFG_CAPTURE_LENGTH: cfg_model.capture_length = psw_pkg::CntW'(val);
      psw_pkg::CFG_INT_START:      cfg_model.int_start = psw_pkg::CntW'(val);
      psw_pkg::CFG_INT_STOP:       cfg_model.int_stop = psw_pkg::CntW'(val);
      psw_pkg::CFG_PED_START:      cfg_model.ped_start = psw_pkg::CntW'(val);
      psw_pkg::CFG_PED_STOP:       cfg_model.ped_stop = psw_pkg::CntW'(val);
      psw_pkg::CFG_RANGE_CHAN_A:   cfg_model.range_chan_a = psw_pkg::RangeIdxW'(val);
      psw_pkg::CFG_RANGE_CHAN_B:   cfg_model.range_chan_b = psw_pkg::RangeIdxW'(val);
      default: ;
    endcase
  endtask

  task automatic write_windows(input int unsigned len, input int unsigned i0,
                               input int unsigned i1, input int unsigned p0,
                               input int unsigned p1);
    write_reg(psw_pkg::CFG_CAPTURE_LENGTH, len);
    write_reg(psw_pkg::CFG_INT_START, i0);
    write_reg(psw_pkg::CFG_INT_STOP, i1);
    write_reg(psw_pkg::CFG_PED_START, p0);
    write_reg(psw_pkg::CFG_PED_STOP, p1);
  endtask

  task automatic push_sample(input int raw, input logic chan);
    sample_t item;
    item.raw = psw_pkg::SampleW'(raw);
    item.chan = chan;
    sample_q.push_back(item);
    samples_pushed++;
  endtask

  // Waits until every queued request is taken and every result has come back.
  task automatic wait_drained();
    while (samples_taken != samples_pushed || charge_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Queues one capture: plain noise, extreme codes, or a baseline with a pulse on it.
  task automatic queue_capture(input int unsigned n);
    int style, base, amp, p0, pw, v;
    style = $urandom_range(0, 3);
    base = int'($urandom_range(0, 16000)) - 8000;
    amp = int'($urandom_range(0, 60000)) - 30000;
    p0 = $urandom_range(0, n - 1);
    pw = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: v = int'($urandom_range(0, 65535)) - 32768;
        3: begin
          case ($urandom_range(0, 7))
            0: v = -32768;
            1: v = 32767;
            2: v = -256;
            3: v = 255;
            4: v = -255;
            5: v = 256;
            6: v = -1;
            default: v = 0;
          endcase
        end
        default: begin
          v = base + int'($urandom_range(0, 1024)) - 512;
          if (i >= p0 && i < p0 + pw) v = v + amp;
        end
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      push_sample(v, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned len_reg, eff, i0, i1, p0, p1;
    int phases;
    cfg_we = 1'b0;
    cfg_idx = psw_pkg::CFG_CAPTURE_LENGTH;
    cfg_data = '0;
    cfg_model = psw_pkg::CfgReset;
    phases = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One capture with the register values left by reset.
    queue_capture(100);
    wait_drained();

    // Full-scale codes and codes at the truncation boundary on both channels with the smallest and largest ranges.
    write_windows(3, 0, 3, 0, 2);
    write_reg(psw_pkg::CFG_RANGE_CHAN_A, 0);
    write_reg(psw_pkg::CFG_RANGE_CHAN_B, 11);
    push_sample(32767, 1'b0);
    push_sample(32767, 1'b1);
    push_sample(32767, 1'b0);
    push_sample(-32768, 1'b0);
    push_sample(-32768, 1'b1);
    push_sample(-32768, 1'b1);
    push_sample(-255, 1'b1);
    push_sample(255, 1'b0);
    push_sample(-256, 1'b0);
    wait_drained();

    // A capture length of zero behaves as one sample.
    write_reg(psw_pkg::CFG_CAPTURE_LENGTH, 0);
    push_sample(32767, 1'b1);
    push_sample(-32768, 1'b0);
    wait_drained();

    // Empty integration window, pedestal disabled, range indexes past the table.
    write_windows(3, 5, 3, 3, 3);
    write_reg(psw_pkg::CFG_RANGE_CHAN_A, 15);
    write_reg(psw_pkg::CFG_RANGE_CHAN_B, 12);
    push_sample(256, 1'b0);
    push_sample(-257, 1'b0);
    push_sample(32767, 1'b0);
    wait_drained();

    // Pedestal enabled but clipped away by the capture length.
    write_windows(3, 0, 8191, 6, 9);
    push_sample(-1, 1'b1);
    push_sample(511, 1'b0);
    push_sample(-32768, 1'b1);
    wait_drained();

    // The capture length is lowered below the current count in the middle of a capture.
    write_windows(10, 1, 10, 0, 4);
    write_reg(psw_pkg::CFG_RANGE_CHAN_A, 3);
    queue_capture(4);
    wait_drained();
    write_reg(psw_pkg::CFG_CAPTURE_LENGTH, 2);
    push_sample(-20000, 1'b0);
    wait_drained();

    // A write to an unused index must change nothing.
    write_reg(CfgIdxSpare, 'h1FFF);
    push_sample(12345, 1'b0);
    push_sample(-12345, 1'b0);
    wait_drained();

    while (samples_pushed < TotalItems) begin
      idle_on = (samples_pushed > TotalItems - 200) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0: len_reg = 0;
        1: len_reg = $urandom_range(41, 300);
        default: len_reg = $urandom_range(1, 40);
      endcase
      eff = (len_reg == 0) ? 1 : len_reg;
      case ($urandom_range(0, 15))
        0: i0 = $urandom_range(4096, 8191);
        default: i0 = $urandom_range(0, eff + 2);
      endcase
      case ($urandom_range(0, 7))
        0: i1 = $urandom_range(4096, 8191);
        1: i1 = 4096;
        default: i1 = $urandom_range(0, eff + 2);
      endcase
      p0 = $urandom_range(0, eff + 2);
      case ($urandom_range(0, 7))
        0, 1: p1 = p0;
        2: p1 = 8191;
        default: p1 = $urandom_range(0, eff + 2);
      endcase
      write_windows(len_reg, i0, i1, p0, p1);
      write_reg(psw_pkg::CFG_RANGE_CHAN_A, $urandom_range(0, 15));
      write_reg(psw_pkg::CFG_RANGE_CHAN_B, $urandom_range(0, 15));
      repeat ($urandom_range(1, 5)) begin
        if (samples_pushed < TotalItems) queue_capture(eff);
      end
      wait_drained();
      phases++;
    end

    repeat (200) @(posedge clk_i);
    $display("Checked %0d capture results from %0d samples over %0d random register settings,",
             captures_checked, samples_taken, phases);
    $display("plus directed cases for extreme codes, empty or clipped windows and length changes.");
    if (fail_count == 0) begin
      $display("pedestal_subtracted_window_integrator test passed");
    end else begin
      $display("pedestal_subtracted_window_integrator test failed");
    end
    $finish;
  end

endmodule
